// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on clk and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ----- hdl/css_pkg.sv -----
// ----------------------------------------------------------------------------
// css_pkg
// shared constants and sequencer state type of the shaker sorter
// ----------------------------------------------------------------------------
package css_pkg;

    // width of the value field on both streams
    localparam int VALUE_WIDTH = 32;

    // sequencer states, one-hot
    typedef enum logic [10:0] {
        S_LOAD    = 11'b000_0000_0001,
        S_B_START = 11'b000_0000_0010,
        S_B_CARRY = 11'b000_0000_0100,
        S_B_STEP  = 11'b000_0000_1000,
        S_B_END   = 11'b000_0001_0000,
        S_F_START = 11'b000_0010_0000,
        S_F_CARRY = 11'b000_0100_0000,
        S_F_STEP  = 11'b000_1000_0000,
        S_F_END   = 11'b001_0000_0000,
        S_E_READ  = 11'b010_0000_0000,
        S_E_LOAD  = 11'b100_0000_0000
    } state_t;

endpackage

// ----- hdl/css_store.sv -----
// ----------------------------------------------------------------------------
// css_store
// element memory with one write port and one registered read port
// ----------------------------------------------------------------------------
module css_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/css_compare.sv -----
// ----------------------------------------------------------------------------
// css_compare
// shared signed compare-and-order unit used by every sort step
// ----------------------------------------------------------------------------
module css_compare #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             greater,
    output logic [WIDTH-1:0] lo,
    output logic [WIDTH-1:0] hi
);

    // signed compare, equal operands keep their order
    assign greater = $signed(a) > $signed(b);
    assign lo      = greater ? b : a;
    assign hi      = greater ? a : b;

endmodule

// ----- hdl/cocktail_shaker_sorter.sv -----
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter
// loads a list of signed words, sorts it ascending by shaker sort, emits it
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)                        ends on
//  s_axis    in   tdata: value[31:0], tlast: last            tlast item
//  m_axis    out  tdata: sorted_value[31:0], tlast:          tlast item
//                 end_of_list, tuser: overflow
//
//  load takes one cycle per item; the list closes on the tlast item
//  sorting walks the store with one compare per cycle, plus a start state,
//  a carry-load state and an end state in each pass
//  each sorted item goes through the emit read and load states via the store
//  read port, and waits in the read state while m_axis holds tready low
//  reset clears control state only; the store is not cleared
//  a new list is taken as soon as the final sorted item sits in m_axis
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cocktail_shaker_sorter
    import css_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int DATA_WIDTH   = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // value
    input  logic [VALUE_WIDTH-1:0] s_axis_tdata,
    input  logic                   s_axis_tlast,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sorted_value
    output logic [VALUE_WIDTH-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    // overflow
    output logic [0:0]             m_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  dropped_reg, dropped_next;
    logic [AW-1:0]         left_reg, left_next;
    logic [AW-1:0]         right_reg, right_next;
    logic [AW-1:0]         scan_reg, scan_next;
    logic [DATA_WIDTH-1:0] carry_reg, carry_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_user_reg, out_user_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic [DATA_WIDTH-1:0] cmp_a, cmp_b, cmp_lo, cmp_hi;
    logic                  cmp_greater;

    logic [DATA_WIDTH-1:0] in_word;
    logic                  in_accept;
    logic [CW-1:0]         n_after;

    // element store
    css_store #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (DATA_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared compare unit
    css_compare #(
        .WIDTH (DATA_WIDTH)
    ) u_compare (
        .a       (cmp_a),
        .b       (cmp_b),
        .greater (cmp_greater),
        .lo      (cmp_lo),
        .hi      (cmp_hi)
    );

    // compare operands: backward pass has the stored word on the left
    assign cmp_a = (state_reg == S_B_STEP) ? mem_rdata : carry_reg;
    assign cmp_b = (state_reg == S_B_STEP) ? carry_reg : mem_rdata;

    // input word fitted to the element width
    assign in_word   = DATA_WIDTH'($signed(s_axis_tdata));
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign n_after   = (count_reg < CW'(MAX_ELEMENTS)) ? count_reg + CW'(1) : count_reg;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        scan_next      = scan_reg;
        carry_next     = carry_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        mem_we         = 1'b0;
        mem_waddr      = scan_reg;
        mem_wdata      = cmp_hi;
        mem_raddr      = scan_reg;

        case (state_reg)
            S_LOAD:
            begin
                mem_waddr = count_reg[AW-1:0];
                mem_wdata = in_word;
                if (in_accept)
                begin
                    if (count_reg < CW'(MAX_ELEMENTS))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        left_next  = '0;
                        right_next = AW'(n_after - CW'(1));
                        if (n_after < CW'(2))
                        begin
                            scan_next  = '0;
                            state_next = S_E_READ;
                        end
                        else
                        begin
                            state_next = S_B_START;
                        end
                    end
                end
            end

            // backward pass: carry the smaller word down to the left bound
            S_B_START:
            begin
                mem_raddr  = right_reg;
                scan_next  = right_reg;
                state_next = S_B_CARRY;
            end

            S_B_CARRY:
            begin
                carry_next = mem_rdata;
                mem_raddr  = scan_reg - AW'(1);
                state_next = S_B_STEP;
            end

            S_B_STEP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = scan_reg;
                mem_wdata  = cmp_hi;
                carry_next = cmp_lo;
                mem_raddr  = scan_reg - AW'(2);
                if ((scan_reg - AW'(1)) == left_reg)
                begin
                    state_next = S_B_END;
                end
                else
                begin
                    scan_next = scan_reg - AW'(1);
                end
            end

            S_B_END:
            begin
                mem_we    = 1'b1;
                mem_waddr = left_reg;
                mem_wdata = carry_reg;
                left_next = left_reg + AW'(1);
                if ((left_reg + AW'(1)) < right_reg)
                begin
                    state_next = S_F_START;
                end
                else
                begin
                    scan_next  = '0;
                    state_next = S_E_READ;
                end
            end

            // forward pass: carry the larger word up to the right bound
            S_F_START:
            begin
                mem_raddr  = left_reg;
                scan_next  = left_reg;
                state_next = S_F_CARRY;
            end

            S_F_CARRY:
            begin
                carry_next = mem_rdata;
                mem_raddr  = scan_reg + AW'(1);
                state_next = S_F_STEP;
            end

            S_F_STEP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = scan_reg;
                mem_wdata  = cmp_lo;
                carry_next = cmp_hi;
                mem_raddr  = scan_reg + AW'(2);
                if ((scan_reg + AW'(1)) == right_reg)
                begin
                    state_next = S_F_END;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end

            S_F_END:
            begin
                mem_we     = 1'b1;
                mem_waddr  = right_reg;
                mem_wdata  = carry_reg;
                right_next = right_reg - AW'(1);
                if (left_reg < (right_reg - AW'(1)))
                begin
                    state_next = S_B_START;
                end
                else
                begin
                    scan_next  = '0;
                    state_next = S_E_READ;
                end
            end

            // emit: read the next word once the output register frees up
            S_E_READ:
            begin
                mem_raddr = scan_reg;
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_E_LOAD;
                end
            end

            S_E_LOAD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = VALUE_WIDTH'($signed(mem_rdata));
                out_user_next  = dropped_reg;
                out_last_next  = (scan_reg == AW'(count_reg - CW'(1)));
                if (scan_reg == AW'(count_reg - CW'(1)))
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = S_LOAD;
                end
                else
                begin
                    scan_next  = scan_reg + AW'(1);
                    state_next = S_E_READ;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        carry_reg    <= carry_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    // assertions
    `ASSERT_CLK(a_back_scan_range, (state_reg == S_B_STEP) |-> (scan_reg > left_reg && scan_reg <= right_reg), "backward scan out of bounds")
    `ASSERT_CLK(a_fwd_scan_range, (state_reg == S_F_STEP) |-> (scan_reg >= left_reg && scan_reg < right_reg), "forward scan out of bounds")
    `ASSERT_NEVER(a_count_cap, count_reg > CW'(MAX_ELEMENTS), "element count above capacity")
    `ASSERT_CLK(a_drop_when_full, $rose(dropped_reg) |-> (count_reg == CW'(MAX_ELEMENTS)), "item dropped below capacity")
    `ASSERT_CLK(a_emit_has_room, (state_reg == S_E_LOAD) |-> !out_valid_reg, "output register overwritten")

endmodule

// ----- tb/sv/sorter_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorter_checker
// watches both streams of the shaker sorter, keeps its own copy of the list
// being loaded, sorts it when the list closes and compares every sorted
// item against the oldest expected one
// ----------------------------------------------------------------------------
module sorter_checker
    import css_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] s_tdata,
    input  logic                   s_tlast,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [VALUE_WIDTH-1:0] m_tdata,
    input  logic                   m_tlast,
    input  logic [0:0]             m_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    output int                     error_count,
    output int                     pending_count
);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          end_of_list;
        logic                          overflow;
    } sorted_item_t;

    // list being loaded and the sorted items still to arrive
    logic signed [VALUE_WIDTH-1:0] held_words[$];
    logic                          words_dropped;
    sorted_item_t                  sorted_queue[$];

    // backward pass raises the left bound, forward pass lowers the right one
    task automatic shaker_sort_held();
        int                            lo_b;
        int                            hi_b;
        int                            i;
        logic signed [VALUE_WIDTH-1:0] tmp;
        if (held_words.size() < 2)
            return;
        lo_b = 0;
        hi_b = held_words.size() - 1;
        while (lo_b < hi_b)
        begin
            for (i = hi_b; i > lo_b; i--)
            begin
                if (held_words[i-1] > held_words[i])
                begin
                    tmp             = held_words[i-1];
                    held_words[i-1] = held_words[i];
                    held_words[i]   = tmp;
                end
            end
            lo_b++;
            for (i = lo_b; i < hi_b; i++)
            begin
                if (held_words[i] > held_words[i+1])
                begin
                    tmp             = held_words[i];
                    held_words[i]   = held_words[i+1];
                    held_words[i+1] = tmp;
                end
            end
            hi_b--;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sorted_item_t want;
        int           k;
        if (!rst_n)
        begin
            held_words.delete();
            sorted_queue.delete();
            words_dropped = 1'b0;
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            // sorted item out: compare with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (sorted_queue.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected item: value %h last %b overflow %b",
                                 m_tdata, m_tlast, m_tuser[0]);
                end
                else
                begin
                    want = sorted_queue.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.end_of_list ||
                        m_tuser[0] !== want.overflow)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: expected value %h last %b overflow %b, %s %h %s %b %s %b",
                                     want.value, want.end_of_list, want.overflow,
                                     "got value", m_tdata, "last", m_tlast,
                                     "overflow", m_tuser[0]);
                    end
                end
            end

            // list item in: hold it, or drop it once the store is full
            if (s_tvalid && s_tready)
            begin
                if (held_words.size() < MAX_ELEMENTS)
                    held_words.push_back(s_tdata);
                else
                    words_dropped = 1'b1;

                // closing item: sort and queue the whole list
                if (s_tlast)
                begin
                    shaker_sort_held();
                    for (k = 0; k < held_words.size(); k++)
                    begin
                        want.value       = held_words[k];
                        want.end_of_list = (k == held_words.size() - 1);
                        want.overflow    = words_dropped;
                        sorted_queue.push_back(want);
                    end
                    held_words.delete();
                    words_dropped = 1'b0;
                end
            end
            pending_count = sorted_queue.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives lists of signed words into the shaker sorter and takes its sorted
// output with random gaps on both sides; a checker beside the block
// predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb;
    import css_pkg::*;

    localparam int RANDOM_ITEMS = 225;
    localparam int DRAIN_CYCLES = 50;

    logic                   clk;
    logic                   rst_n;
    logic [VALUE_WIDTH-1:0] s_tdata;
    logic                   s_tlast;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VALUE_WIDTH-1:0] m_tdata;
    logic                   m_tlast;
    logic [0:0]             m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   calm;
    int                     error_count;
    int                     pending_count;

    // directed lists, {last, value}
    logic [VALUE_WIDTH:0]   directed_items[$];

    cocktail_shaker_sorter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .m_axis_tuser  (m_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready)
    );

    sorter_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random back-pressure, none during the calm stretch
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    // random word, weighted toward extremes and small repeated values
    function automatic logic [VALUE_WIDTH-1:0] pick_word();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       pick_word = 32'h8000_0000;
            1:       pick_word = 32'h7fff_ffff;
            2, 3:    pick_word = $urandom_range(8) - 4;
            default: pick_word = $urandom;
        endcase
    endfunction

    // one item on s_axis, called and returning at a falling edge
    task automatic send_item(input logic [VALUE_WIDTH-1:0] word, input logic closes);
        while (!calm && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= word;
        s_tlast  <= closes;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        int i;
        int n;
        int k;
        int rand_items;
        int list_idx;

        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tvalid = 1'b0;
        calm     = 1'b0;
        rst_n    = 1'b0;
        directed_items = '{
            {1'b1, 32'h0000_0000},
            {1'b0, 32'h7fff_ffff}, {1'b1, 32'h8000_0000},
            {1'b0, 32'hffff_ffff}, {1'b0, 32'h0000_0000}, {1'b0, 32'h0000_0001},
            {1'b0, 32'h8000_0000}, {1'b1, 32'h7fff_ffff},
            {1'b0, 32'h0000_0005}, {1'b0, 32'h0000_0005}, {1'b0, 32'hffff_fffb},
            {1'b1, 32'h0000_0005},
            {1'b0, 32'h0000_0001}, {1'b0, 32'h0000_0002}, {1'b0, 32'h0000_0003},
            {1'b1, 32'h0000_0004},
            {1'b0, 32'h0000_0004}, {1'b0, 32'h0000_0003}, {1'b0, 32'h0000_0002},
            {1'b0, 32'h0000_0001}, {1'b0, 32'h0000_0000}, {1'b1, 32'hffff_ffff}
        };

        // reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed lists: one element, extremes, duplicates, sorted, reversed
        for (i = 0; i < directed_items.size(); i++)
            send_item(directed_items[i][VALUE_WIDTH-1:0], directed_items[i][VALUE_WIDTH]);

        // random lists: mostly short, one exactly full, one past capacity, now and then a long one of 56 to 70 items
        rand_items = 0;
        list_idx   = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (list_idx == 2)
                n = 64;
            else if (list_idx == 6)
                n = 66;
            else if ($urandom_range(14) == 0)
                n = $urandom_range(70, 56);
            else
                n = $urandom_range(12, 1);
            calm <= (list_idx >= 9 && list_idx < 16);
            for (k = 0; k < n; k++)
                send_item(pick_word(), k == n - 1);
            rand_items += n;
            list_idx++;
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        // drain
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
